[hdl/mts_pkg.sv]
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and codes of the min tracking stack: operation and status
// codes and the layout of one stored entry.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam logic [1:0] MODE_PUSH = 2'd0;
  localparam logic [1:0] MODE_POP  = 2'd1;
  localparam logic [1:0] MODE_PEEK = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ENTRY_W = 2 * DATA_W;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] min;
  } entry_t;

endpackage

[hdl/mts_req_if.sv]
// ----------------------------------------------------------------------------
// mts_req_if
// Request channel of the min tracking stack: operation and operand.
// ----------------------------------------------------------------------------
interface mts_req_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  mode;
  logic signed [31:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink (input valid, input mode, input value, output ready);
endinterface

[hdl/mts_rsp_if.sv]
// ----------------------------------------------------------------------------
// mts_rsp_if
// Response channel of the min tracking stack: status, item, minimum, count.
// ----------------------------------------------------------------------------
interface mts_rsp_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic signed [31:0] item_value;
  logic signed [31:0] min_value;
  logic        [7:0]  count;

  modport source (output valid, output status, output item_value, output min_value,
                  output count, input ready);
  modport sink (input valid, input status, input item_value, input min_value,
                input count, output ready);
endinterface

[hdl/min_tracking_stack_unit.sv]
// ----------------------------------------------------------------------------
// min_tracking_stack_unit
// LIFO stack of signed values that keeps the running minimum of its contents.
//
//   channel | dir | transaction content
//   --------+-----+------------------------------------------------
//   req     | in  | mode (push, pop, peek), value to push
//   rsp     | out | status, item_value, min_value, count
//
// The top entry sits in registers, the entries below it in one RAM.
// Push and peek load the response straight from ST_IDLE; a pop that leaves
// entries behind passes through ST_RELOAD, waiting for the RAM read of the new top entry.
// A request is taken while the previous response is being drained.
// rst clears the entry count; RAM contents need no clearing.
// ----------------------------------------------------------------------------
module min_tracking_stack_unit #(
  parameter int DEPTH = 128
) (
  input logic    clk,
  input logic    rst,
  mts_req_if.sink   req,
  mts_rsp_if.source rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_RELOAD = 2'b10
  } state_t;

  state_t state, state_next;

  logic [CW-1:0]      count, count_next;
  logic signed [31:0] top_value, top_value_next;
  logic signed [31:0] top_min, top_min_next;
  logic signed [31:0] pop_value, pop_value_next;

  logic               out_valid, out_valid_next;
  logic [1:0]         out_status, out_status_next;
  logic signed [31:0] out_item, out_item_next;
  logic signed [31:0] out_min, out_min_next;
  logic [7:0]         out_count, out_count_next;
  logic               out_load;

  logic               req_fire;
  logic signed [31:0] push_min;

  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  mts_pkg::entry_t     wr_entry;
  logic [AW-1:0]       rd_addr;
  mts_pkg::entry_t     rd_entry;

  mts_ram #(
    .WIDTH(mts_pkg::ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_entry),
    .rd_addr(rd_addr),
    .rd_data(rd_entry)
  );

  assign req.ready = (state == ST_IDLE) && (!out_valid || rsp.ready);
  assign req_fire  = req.valid && req.ready;

  assign wr_addr  = AW'(count - CW'(1));
  assign rd_addr  = AW'(count - CW'(2));
  assign wr_entry = '{value: top_value, min: top_min};
  assign push_min = ((count == '0) || (req.value <= top_min)) ? req.value : top_min;

  always_comb begin
    state_next      = state;
    count_next      = count;
    top_value_next  = top_value;
    top_min_next    = top_min;
    pop_value_next  = pop_value;
    wr_en           = 1'b0;
    out_load        = 1'b0;
    out_status_next = out_status;
    out_item_next   = out_item;
    out_min_next    = out_min;
    out_count_next  = out_count;

    case (state)
      ST_IDLE: begin
        if (req_fire) begin
          case (req.mode)
            mts_pkg::MODE_PUSH: begin
              out_load = 1'b1;
              if (count == CW'(DEPTH)) begin
                out_status_next = mts_pkg::STATUS_FULL;
                out_item_next   = '0;
                out_min_next    = top_min;
                out_count_next  = 8'(count);
              end else begin
                wr_en           = (count != '0);
                top_value_next  = req.value;
                top_min_next    = push_min;
                count_next      = count + CW'(1);
                out_status_next = mts_pkg::STATUS_OK;
                out_item_next   = req.value;
                out_min_next    = push_min;
                out_count_next  = 8'(count + CW'(1));
              end
            end
            mts_pkg::MODE_POP: begin
              if (count == '0) begin
                out_load        = 1'b1;
                out_status_next = mts_pkg::STATUS_EMPTY;
                out_item_next   = '0;
                out_min_next    = '0;
                out_count_next  = '0;
              end else if (count == CW'(1)) begin
                out_load        = 1'b1;
                count_next      = '0;
                out_status_next = mts_pkg::STATUS_OK;
                out_item_next   = top_value;
                out_min_next    = '0;
                out_count_next  = '0;
              end else begin
                pop_value_next = top_value;
                count_next     = count - CW'(1);
                state_next     = ST_RELOAD;
              end
            end
            default: begin
              out_load = 1'b1;
              if (count == '0) begin
                out_status_next = mts_pkg::STATUS_EMPTY;
                out_item_next   = '0;
                out_min_next    = '0;
                out_count_next  = '0;
              end else begin
                out_status_next = mts_pkg::STATUS_OK;
                out_item_next   = top_value;
                out_min_next    = top_min;
                out_count_next  = 8'(count);
              end
            end
          endcase
        end
      end
      ST_RELOAD: begin
        top_value_next  = rd_entry.value;
        top_min_next    = rd_entry.min;
        out_load        = 1'b1;
        out_status_next = mts_pkg::STATUS_OK;
        out_item_next   = pop_value;
        out_min_next    = rd_entry.min;
        out_count_next  = 8'(count);
        state_next      = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (rsp.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
    top_value  <= top_value_next;
    top_min    <= top_min_next;
    pop_value  <= pop_value_next;
    out_status <= out_status_next;
    out_item   <= out_item_next;
    out_min    <= out_min_next;
    out_count  <= out_count_next;
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.item_value = out_item;
  assign rsp.min_value  = out_min;
  assign rsp.count      = out_count;

  // a pop that leaves entries behind waits for the ram read
  a_pop_reload: assert property (@(posedge clk) disable iff (rst)
    (req_fire && req.mode == mts_pkg::MODE_POP && count > CW'(1)) |=> state == ST_RELOAD)
    else $error("pop with entries left did not reload the top entry");

  // no request is taken while the top entry is being reloaded
  a_no_accept_reload: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RELOAD) |-> !req.ready)
    else $error("request accepted during reload");

  // the entry count stays within the stack depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count beyond depth");

  // a response of an empty stack reports no entries and a zero minimum
  a_empty_rsp: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status == mts_pkg::STATUS_EMPTY) |-> (count == '0 && out_min == '0))
    else $error("empty status with stored entries");

endmodule

[hdl/mts_ram.sv]
// ----------------------------------------------------------------------------
// mts_ram
// Generic simple dual port RAM, one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
module mts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
